// ===== hdl/qnbe_pkg.sv =====
// Shared types and constants for the quadtree node bit encoder.
package qnbe_pkg;

    localparam int IDX_W   = 19;   // node_index width
    localparam int BITS_W  = 19;   // most bits one node can produce
    localparam int NB_W    = 5;    // bit count width
    localparam int ACC_W   = 26;   // 7 pending bits plus one node's bits
    localparam int QDEPTH  = 4;    // front-to-back queue depth
    localparam int QAW     = 2;    // queue pointer width
    localparam int QLW     = 3;    // queue level width (holds QDEPTH)

    // One classified node: bits left-aligned, earliest bit in the MSB.
    typedef struct packed {
        logic [BITS_W-1:0] bits;
        logic [NB_W-1:0]   nbits;
        logic              root;   // drop pending bits before these
        logic              last;   // flush after these
    } qnbe_entry_t;

    typedef struct packed {
        logic           empty;
        logic [QLW-1:0] level;
    } qnbe_qstat_t;

endpackage

// ===== hdl/qnbe_front.sv =====
// Front end: accepts nodes, keeps the uniform flag store, classifies bits.
module qnbe_front #(
    parameter int unsigned MAX_NODES = 524288
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic                 s_tlast,
    input  logic [7:0]           tree_depth,
    input  qnbe_pkg::qnbe_qstat_t q_stat,
    output logic                 q_push,
    output qnbe_pkg::qnbe_entry_t q_wdata
);
    import qnbe_pkg::*;

    localparam int unsigned STORE_DEPTH = (MAX_NODES + 3) / 4;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic mem [STORE_DEPTH];

    logic [IDX_W-1:0] idx;
    logic [31:0]      idx32;
    logic [31:0]      par32;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             accept;
    logic             in_range;
    logic             store_ok;

    logic             p_valid_reg;
    logic             p_ok_reg;
    logic             p_root_reg;
    logic             p_fourth_reg;
    logic [7:0]       p_mean_reg;
    logic [1:0]       p_eps_reg;
    logic             p_uni_reg;
    logic             p_leaf_reg;
    logic             p_last_reg;
    logic             rd_reg;

    logic [15:0]      a_bits;
    logic [NB_W-1:0]  na;
    logic [2:0]       tail;
    logic [NB_W-1:0]  nt;
    logic             emit_ok;
    logic [QLW:0]     inflight;

    assign idx      = s_tdata[18:0];
    assign idx32    = 32'(idx);
    assign par32    = (idx32 - 32'd1) >> 2;
    assign rd_addr  = par32[AW-1:0];
    assign wr_addr  = idx32[AW-1:0];
    assign in_range = idx32 < MAX_NODES;
    assign store_ok = in_range && (idx32 < STORE_DEPTH);

    // stage register can always drain into the queue, so count it as taken
    assign inflight = {1'b0, q_stat.level} + {{QLW{1'b0}}, p_valid_reg};
    assign s_tready = inflight < (QLW+1)'(QDEPTH);
    assign accept   = s_tvalid && s_tready;

    // parent always precedes child by at least one transaction, so a
    // read-first memory with registered output needs no bypass
    always_ff @(posedge aclk) begin
        if (accept && store_ok) begin
            mem[wr_addr] <= s_tdata[29];
        end
        if (accept) begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_ok_reg     <= in_range;
            p_root_reg   <= (idx == '0);
            p_fourth_reg <= (idx[1:0] == 2'b00);
            p_mean_reg   <= s_tdata[26:19];
            p_eps_reg    <= s_tdata[28:27];
            p_uni_reg    <= s_tdata[29];
            p_leaf_reg   <= s_tdata[30];
            p_last_reg   <= s_tlast;
        end
    end

    always_comb begin
        emit_ok = p_ok_reg && (p_root_reg || !rd_reg);

        if (p_root_reg) begin
            a_bits = {tree_depth, p_mean_reg};
            na     = NB_W'(16);
        end else if (!p_fourth_reg) begin
            a_bits = {p_mean_reg, 8'h00};
            na     = NB_W'(8);
        end else begin
            a_bits = 16'h0000;
            na     = '0;
        end

        if (p_leaf_reg) begin
            tail = 3'b000;
            nt   = '0;
        end else if (p_eps_reg == 2'b00) begin
            tail = {p_eps_reg, p_uni_reg};
            nt   = NB_W'(3);
        end else begin
            tail = {p_eps_reg, 1'b0};
            nt   = NB_W'(2);
        end

        q_wdata.root = p_ok_reg && p_root_reg;
        q_wdata.last = p_last_reg;
        if (emit_ok) begin
            q_wdata.bits  = {a_bits, 3'b000} | ({tail, 16'h0000} >> na);
            q_wdata.nbits = na + nt;
        end else begin
            q_wdata.bits  = '0;
            q_wdata.nbits = '0;
        end
        q_push = p_valid_reg && ((q_wdata.nbits != '0) || p_last_reg);
    end

endmodule

// ===== hdl/qnbe_queue.sv =====
// Short FIFO between the classifier and the bit packer.
module qnbe_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  qnbe_pkg::qnbe_entry_t wdata,
    input  logic                  pop,
    output qnbe_pkg::qnbe_entry_t head,
    output qnbe_pkg::qnbe_qstat_t stat
);
    import qnbe_pkg::*;

    qnbe_entry_t    slot_reg [QDEPTH];
    logic [QAW-1:0] wp_reg, wp_next;
    logic [QAW-1:0] rp_reg, rp_next;
    logic [QLW-1:0] lvl_reg, lvl_next;

    always_comb begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        lvl_next = lvl_reg + QLW'(push) - QLW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            lvl_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            lvl_reg <= lvl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= wdata;
        end
    end

    assign head       = slot_reg[rp_reg];
    assign stat.empty = (lvl_reg == '0);
    assign stat.level = lvl_reg;

endmodule

// ===== hdl/qnbe_back.sv =====
// Back end: accumulates node bits; one byte per cycle unless m_tready stalls.
module qnbe_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  qnbe_pkg::qnbe_entry_t head,
    input  qnbe_pkg::qnbe_qstat_t q_stat,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast
);
    import qnbe_pkg::*;

    // w holds pending bits left-aligned; bits past cnt are always zero
    logic [ACC_W-1:0] w_reg, w_next;
    logic [NB_W-1:0]  cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic             mv_reg, mv_next;
    logic [7:0]       md_reg, md_next;
    logic             ml_reg, ml_next;

    logic             out_free;
    logic             load;
    logic [ACC_W-1:0] mw, cur_w;
    logic [NB_W-1:0]  mc, cur_cnt;
    logic             cur_last;

    always_comb begin
        out_free = !mv_reg || m_tready;
        load     = out_free && !last_reg && (cnt_reg < NB_W'(8)) && !q_stat.empty;

        if (head.root) begin
            mw = {head.bits, 7'b0};
            mc = head.nbits;
        end else begin
            mw = w_reg | ({head.bits, 7'b0} >> cnt_reg[2:0]);
            mc = cnt_reg + head.nbits;
        end

        cur_w    = load ? mw : w_reg;
        cur_cnt  = load ? mc : cnt_reg;
        cur_last = load ? head.last : last_reg;

        w_next    = w_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        mv_next   = mv_reg;
        md_next   = md_reg;
        ml_next   = ml_reg;

        if (out_free) begin
            if (cur_cnt >= NB_W'(8)) begin
                mv_next   = 1'b1;
                md_next   = cur_w[ACC_W-1 -: 8];
                ml_next   = cur_last && (cur_cnt == NB_W'(8));
                w_next    = cur_w << 8;
                cnt_next  = cur_cnt - NB_W'(8);
                last_next = cur_last && (cur_cnt != NB_W'(8));
            end else if (cur_last) begin
                // zero-padded flush of the partial byte
                mv_next   = (cur_cnt != '0);
                md_next   = cur_w[ACC_W-1 -: 8];
                ml_next   = 1'b1;
                w_next    = '0;
                cnt_next  = '0;
                last_next = 1'b0;
            end else begin
                mv_next   = 1'b0;
                w_next    = cur_w;
                cnt_next  = cur_cnt;
                last_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg    <= '0;
            cnt_reg  <= '0;
            last_reg <= 1'b0;
            mv_reg   <= 1'b0;
        end else begin
            w_reg    <= w_next;
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
            mv_reg   <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        md_reg <= md_next;
        ml_reg <= ml_next;
    end

    assign q_pop    = load;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

endmodule

// ===== hdl/quadtree_node_bit_encoder.sv =====
// Top level of the quadtree node bit encoder.
//
//  port group    | dir | contents
//  --------------+-----+--------------------------------------------------
//  s_t*          | in  | one quadtree node per transaction
//  m_t*          | out | one packed byte per transaction
//  cfg_we/wdata  | in  | tree depth register, write only
//
// A node can be accepted every cycle while the 4-entry queue has room; a node
// that yields bits or is last passes the stage register into the queue (store read
// and classify share one stage). The packer emits one byte per cycle unless
// m_tready stalls; it takes the next node only once fewer than 8 bits are pending,
// and it flushes a last node's partial byte zero-padded.
// Reset clears control state; the uniform flag store is not cleared.
// A stalled m_tready backs up the queue and then s_tready, nothing is lost.
module quadtree_node_bit_encoder #(
    parameter int unsigned MAX_NODES = 524288
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // node_index[18:0], mean_value[26:19],
                                   // error_class[28:27], uniform[29],
                                   // is_leaf[30], zero[31]
    input  logic        s_tlast,   // last_node
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,   // final_byte
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import qnbe_pkg::*;

    logic [7:0]  tree_depth_reg;
    logic        q_push;
    logic        q_pop;
    qnbe_entry_t q_wdata;
    qnbe_entry_t q_head;
    qnbe_qstat_t q_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tree_depth_reg <= 8'h00;
        end else if (cfg_we) begin
            tree_depth_reg <= cfg_wdata;
        end
    end

    qnbe_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .tree_depth (tree_depth_reg),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    qnbe_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .head    (q_head),
        .stat    (q_stat)
    );

    qnbe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
